// ===== rtl/hpq_pkg.sv =====
// Shared types, constants and the key ordering function for the min-heap priority queue.
`default_nettype none

package hpq_pkg;

    localparam int CAPACITY    = 64;
    localparam int KEY_WIDTH   = 32;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int IDX_W       = ADDR_W + 2;
    localparam int IN_TDATA_W  = ((KEY_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((KEY_WIDTH + CNT_W + 7) / 8) * 8;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    localparam logic [0:0] REG_COMPARE_SIGNED = 1'b0;

    typedef logic [KEY_WIDTH-1:0] key_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic accept;
        logic ins_begin;
        logic ext_begin;
        logic set_full;
        logic set_empty;
        logic ext_load;
        logic rd_parent;
        logic rd_children;
        logic wr_elem;
        logic up_step;
        logic dn_step;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic is_extract;
        logic full;
        logic empty;
        logic pos_zero;
        logic count_zero;
        logic up_less;
        logic lc_valid;
        logic dn_move;
        logic out_free;
    } dp_stat_t;

    function automatic logic key_less(input key_t a, input key_t b, input logic sgn);
        key_t flip;
        flip = '0;
        flip[KEY_WIDTH-1] = sgn;
        return (a ^ flip) < (b ^ flip);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/binary_min_heap_priority_queue_unit.sv =====
// Top level of the min-heap priority queue: stream ports, configuration register, controller and datapath.
//
// Each input beat either inserts a key (tuser 0) or extracts the minimum (tuser 1), and yields
// exactly one output beat carrying the extracted key, a status code and the occupancy after the
// operation. Items are handled one at a time; the cost is set by the single heap RAM with a
// registered read, where every heap level takes a read state and a compare-and-write state.
// An insert moves its key up at most 6 levels at capacity 64 and stops at the root or below
// it. An extract moves the last key from the root down at most 5 levels and ends on a node
// without children or above its children, or skips the sift when the heap becomes empty. A
// dropped insert or an extract from an empty heap goes straight to the result. A new beat is
// taken while the previous result still waits in the output register, but its own result waits
// until that register is free. The ordering register compare_signed (address 0) selects
// unsigned or two's complement comparison and must only be written while the queue is idle.
`default_nettype none

module binary_min_heap_priority_queue_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // s_tdata: key
    input  wire logic [hpq_pkg::IN_TDATA_W-1:0]      s_tdata,
    // s_tuser: operation
    input  wire logic                                s_tuser,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // m_tdata: min_key, occupancy, zero padding
    output logic      [hpq_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // m_tuser: status
    output logic      [1:0]                          m_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [hpq_pkg::CFG_ADDR_W-1:0]      paddr,
    input  wire logic [hpq_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic      [hpq_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                     pready
);

    hpq_pkg::dp_cmd_t  cmd;
    hpq_pkg::dp_stat_t stat;

    logic       cs_reg, cs_next;
    logic [0:0] reg_index;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign reg_index = paddr[hpq_pkg::CFG_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        cs_next = cs_reg;
        if (cfg_write && reg_index == hpq_pkg::REG_COMPARE_SIGNED)
        begin
            cs_next = pwdata[0];
        end
        prdata = '0;
        if (reg_index == hpq_pkg::REG_COMPARE_SIGNED)
        begin
            prdata = {{(hpq_pkg::CFG_DATA_W - 1){1'b0}}, cs_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cs_reg <= 1'b0;
        end
        else
        begin
            cs_reg <= cs_next;
        end
    end

    hpq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    hpq_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .in_op          (s_tuser),
        .in_key         (s_tdata),
        .compare_signed (cs_reg),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser)
    );

endmodule

`default_nettype wire

// ===== rtl/hpq_ram.sv =====
// Generic RAM with one write port and two registered read ports.
`default_nettype none

module hpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic      [WIDTH-1:0]         rd_data_a,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic      [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

`default_nettype wire

// ===== rtl/hpq_datapath.sv =====
// Datapath of the heap: key store, sift position, occupancy count, comparators and output register.
`default_nettype none

module hpq_datapath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire hpq_pkg::dp_cmd_t                    cmd,
    output hpq_pkg::dp_stat_t                        stat,
    input  wire logic                                in_op,
    input  wire logic [hpq_pkg::IN_TDATA_W-1:0]      in_key,
    input  wire logic                                compare_signed,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic      [hpq_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic      [1:0]                          m_tuser
);

    localparam int AW = hpq_pkg::ADDR_W;
    localparam int CW = hpq_pkg::CNT_W;
    localparam int IW = hpq_pkg::IDX_W;

    logic              op_reg, op_next;
    hpq_pkg::key_t     elem_reg, elem_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     pos_reg, pos_next;
    hpq_pkg::key_t     min_reg, min_next;
    hpq_pkg::status_t  status_reg, status_next;
    logic              out_valid_reg, out_valid_next;
    hpq_pkg::key_t     out_key_reg, out_key_next;
    hpq_pkg::status_t  out_status_reg, out_status_next;
    logic [CW-1:0]     out_occ_reg, out_occ_next;

    logic [IW-1:0]     pos_ext, count_ext, lc, rc;
    logic [AW-1:0]     parent_addr, last_addr, dn_pos;
    logic [CW-1:0]     count_dec;
    logic              rc_valid, l_less, r_less, up_less;
    hpq_pkg::key_t     best_key, dn_key;

    logic              wr_en;
    logic [AW-1:0]     wr_addr, rd_addr_a, rd_addr_b;
    hpq_pkg::key_t     wr_data, rd_a, rd_b;

    assign pos_ext     = IW'(pos_reg);
    assign count_ext   = IW'(count_reg);
    assign lc          = (pos_ext << 1) + IW'(1);
    assign rc          = (pos_ext << 1) + IW'(2);
    assign parent_addr = (pos_reg - AW'(1)) >> 1;
    assign count_dec   = count_reg - CW'(1);
    assign last_addr   = count_dec[AW-1:0];
    assign rc_valid    = rc < count_ext;

    assign up_less  = hpq_pkg::key_less(elem_reg, rd_a, compare_signed);
    assign l_less   = hpq_pkg::key_less(rd_a, elem_reg, compare_signed);
    assign best_key = l_less ? rd_a : elem_reg;
    assign r_less   = rc_valid && hpq_pkg::key_less(rd_b, best_key, compare_signed);
    assign dn_key   = r_less ? rd_b : rd_a;
    assign dn_pos   = r_less ? rc[AW-1:0] : lc[AW-1:0];

    always_comb
    begin
        stat.is_extract = (op_reg == hpq_pkg::OP_EXTRACT);
        stat.full       = (count_reg == CW'(hpq_pkg::CAPACITY));
        stat.empty      = (count_reg == '0);
        stat.pos_zero   = (pos_reg == '0);
        stat.count_zero = (count_reg == '0);
        stat.up_less    = up_less;
        stat.lc_valid   = lc < count_ext;
        stat.dn_move    = l_less || r_less;
        stat.out_free   = !out_valid_reg || m_tready;
    end

    always_comb
    begin
        priority if (cmd.ext_begin)
        begin
            rd_addr_a = '0;
        end
        else if (cmd.rd_parent)
        begin
            rd_addr_a = parent_addr;
        end
        else
        begin
            rd_addr_a = lc[AW-1:0];
        end
        rd_addr_b = cmd.ext_begin ? last_addr : rc[AW-1:0];
        wr_en     = cmd.wr_elem || cmd.up_step || cmd.dn_step;
        wr_addr   = pos_reg;
        priority if (cmd.up_step)
        begin
            wr_data = rd_a;
        end
        else if (cmd.dn_step)
        begin
            wr_data = dn_key;
        end
        else
        begin
            wr_data = elem_reg;
        end
    end

    hpq_ram #(
        .WIDTH (hpq_pkg::KEY_WIDTH),
        .DEPTH (hpq_pkg::CAPACITY)
    ) u_store (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_data_a (rd_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_b (rd_b)
    );

    always_comb
    begin
        op_next         = op_reg;
        elem_next       = elem_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        min_next        = min_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg;
        out_key_next    = out_key_reg;
        out_status_next = out_status_reg;
        out_occ_next    = out_occ_reg;

        if (cmd.accept)
        begin
            op_next   = in_op;
            elem_next = in_key[hpq_pkg::KEY_WIDTH-1:0];
        end
        if (cmd.ins_begin)
        begin
            pos_next    = count_reg[AW-1:0];
            count_next  = count_reg + CW'(1);
            status_next = hpq_pkg::ST_OK;
            min_next    = '0;
        end
        if (cmd.ext_begin)
        begin
            count_next  = count_dec;
            status_next = hpq_pkg::ST_OK;
        end
        if (cmd.set_full)
        begin
            status_next = hpq_pkg::ST_FULL;
            min_next    = '0;
        end
        if (cmd.set_empty)
        begin
            status_next = hpq_pkg::ST_EMPTY;
            min_next    = '0;
        end
        if (cmd.ext_load)
        begin
            min_next  = rd_a;
            elem_next = rd_b;
            pos_next  = '0;
        end
        if (cmd.up_step)
        begin
            pos_next = parent_addr;
        end
        if (cmd.dn_step)
        begin
            pos_next = dn_pos;
        end
        if (cmd.out_load)
        begin
            out_valid_next  = 1'b1;
            out_key_next    = min_reg;
            out_status_next = status_reg;
            out_occ_next    = count_reg;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        elem_reg       <= elem_next;
        pos_reg        <= pos_next;
        min_reg        <= min_next;
        status_reg     <= status_next;
        out_key_reg    <= out_key_next;
        out_status_reg <= out_status_next;
        out_occ_reg    <= out_occ_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(hpq_pkg::OUT_TDATA_W - hpq_pkg::KEY_WIDTH - CW){1'b0}},
                       out_occ_reg, out_key_reg};
    assign m_tuser  = out_status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(hpq_pkg::CAPACITY))
        else $error("Occupancy count exceeds the heap capacity.");

    a_write_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (pos_ext < count_ext))
        else $error("Store write lands outside the occupied part of the heap.");

    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == hpq_pkg::ST_FULL)
            |-> (out_occ_reg == CW'(hpq_pkg::CAPACITY)))
        else $error("Full status reported while the heap is not full.");

    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == hpq_pkg::ST_EMPTY) |-> (out_occ_reg == '0))
        else $error("Empty status reported while the heap holds keys.");

endmodule

`default_nettype wire

// ===== rtl/hpq_ctrl.sv =====
// Controller state machine that sequences insert, extract and the sift steps of the heap.
`default_nettype none

module hpq_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire hpq_pkg::dp_stat_t stat,
    output hpq_pkg::dp_cmd_t       cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_EX_LOAD,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RD,
        S_DN_CMP,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (!stat.is_extract)
                begin
                    if (stat.full)
                    begin
                        cmd.set_full = 1'b1;
                        state_next   = S_DONE;
                    end
                    else
                    begin
                        cmd.ins_begin = 1'b1;
                        state_next    = S_UP_RD;
                    end
                end
                else if (stat.empty)
                begin
                    cmd.set_empty = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    cmd.ext_begin = 1'b1;
                    state_next    = S_EX_LOAD;
                end
            end
            S_EX_LOAD:
            begin
                cmd.ext_load = 1'b1;
                state_next   = stat.count_zero ? S_DONE : S_DN_RD;
            end
            S_UP_RD:
            begin
                if (stat.pos_zero)
                begin
                    cmd.wr_elem = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.rd_parent = 1'b1;
                    state_next    = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                if (stat.up_less)
                begin
                    cmd.up_step = 1'b1;
                    state_next  = S_UP_RD;
                end
                else
                begin
                    cmd.wr_elem = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_DN_RD:
            begin
                if (stat.lc_valid)
                begin
                    cmd.rd_children = 1'b1;
                    state_next      = S_DN_CMP;
                end
                else
                begin
                    cmd.wr_elem = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_DN_CMP:
            begin
                if (stat.dn_move)
                begin
                    cmd.dn_step = 1'b1;
                    state_next  = S_DN_RD;
                end
                else
                begin
                    cmd.wr_elem = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/binary_min_heap_priority_queue_unit_tb.sv =====
// Self-checking testbench for the min-heap priority queue: directed table, then random phases.
`default_nettype none

module binary_min_heap_priority_queue_unit_tb;

    import hpq_pkg::*;

    typedef struct packed {
        key_t                   min_key;
        status_t                status;
        logic [CNT_W-1:0]       occupancy;
    } heap_reply_t;

    typedef struct packed {
        bit                     sgn;
        logic                   op;
        key_t                   key;
        bit                     typed;
        heap_reply_t            reply;
    } step_row_t;

    localparam int DIRECTED_ROWS = 25;

    localparam step_row_t DIRECTED_STEPS [DIRECTED_ROWS] = '{
        '{1'b0, OP_EXTRACT, 32'h0000_0000, 1'b1, '{32'h0000_0000, ST_EMPTY, 7'd0}},
        '{1'b0, OP_EXTRACT, 32'hA5A5_A5A5, 1'b1, '{32'h0000_0000, ST_EMPTY, 7'd0}},
        '{1'b0, OP_INSERT,  32'h0000_0000, 1'b1, '{32'h0000_0000, ST_OK,    7'd1}},
        '{1'b0, OP_INSERT,  32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, ST_OK,    7'd2}},
        '{1'b0, OP_INSERT,  32'h8000_0000, 1'b1, '{32'h0000_0000, ST_OK,    7'd3}},
        '{1'b0, OP_INSERT,  32'h7FFF_FFFF, 1'b1, '{32'h0000_0000, ST_OK,    7'd4}},
        '{1'b0, OP_INSERT,  32'h0000_0001, 1'b1, '{32'h0000_0000, ST_OK,    7'd5}},
        '{1'b0, OP_INSERT,  32'h0000_0001, 1'b1, '{32'h0000_0000, ST_OK,    7'd6}},
        '{1'b0, OP_EXTRACT, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, ST_OK,    7'd5}},
        '{1'b0, OP_EXTRACT, 32'h0000_0000, 1'b1, '{32'h0000_0001, ST_OK,    7'd4}},
        '{1'b0, OP_EXTRACT, 32'h0000_0000, 1'b1, '{32'h0000_0001, ST_OK,    7'd3}},
        '{1'b0, OP_EXTRACT, 32'h0000_0000, 1'b1, '{32'h7FFF_FFFF, ST_OK,    7'd2}},
        '{1'b0, OP_EXTRACT, 32'h0000_0000, 1'b1, '{32'h8000_0000, ST_OK,    7'd1}},
        '{1'b0, OP_EXTRACT, 32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, ST_OK,    7'd0}},
        '{1'b0, OP_EXTRACT, 32'h0000_0000, 1'b1, '{32'h0000_0000, ST_EMPTY, 7'd0}},
        '{1'b1, OP_INSERT,  32'h7FFF_FFFF, 1'b1, '{32'h0000_0000, ST_OK,    7'd1}},
        '{1'b1, OP_INSERT,  32'h8000_0000, 1'b1, '{32'h0000_0000, ST_OK,    7'd2}},
        '{1'b1, OP_INSERT,  32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, ST_OK,    7'd3}},
        '{1'b1, OP_INSERT,  32'h0000_0000, 1'b1, '{32'h0000_0000, ST_OK,    7'd4}},
        '{1'b1, OP_EXTRACT, 32'h0000_0000, 1'b1, '{32'h8000_0000, ST_OK,    7'd3}},
        '{1'b1, OP_EXTRACT, 32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, ST_OK,    7'd2}},
        '{1'b1, OP_EXTRACT, 32'h0000_0000, 1'b1, '{32'h0000_0000, ST_OK,    7'd1}},
        '{1'b1, OP_EXTRACT, 32'h0000_0000, 1'b1, '{32'h7FFF_FFFF, ST_OK,    7'd0}},
        '{1'b1, OP_INSERT,  32'h1234_5678, 1'b0, '{32'h0000_0000, ST_OK,    7'd0}},
        '{1'b1, OP_EXTRACT, 32'h5A5A_5A5A, 1'b0, '{32'h0000_0000, ST_OK,    7'd0}}
    };

    localparam int PHASES         = 10;
    localparam int PHASE_ITEMS    = 200;
    localparam int SETTLE_CYCLES  = 24;

    logic                       clk;
    logic                       rst_n;
    logic [IN_TDATA_W-1:0]      s_tdata;
    logic                       s_tuser;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [OUT_TDATA_W-1:0]     m_tdata;
    logic [1:0]                 m_tuser;
    logic                       m_tvalid;
    logic                       m_tready;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [CFG_ADDR_W-1:0]      paddr;
    logic [CFG_DATA_W-1:0]      pwdata;
    logic [CFG_DATA_W-1:0]      prdata;
    logic                       pready;

    key_t                       model_keys [CAPACITY];
    int                         model_count;
    bit                         order_signed;
    heap_reply_t                awaited_replies [$];

    int                         error_count;
    int                         n_inserts;
    int                         n_dropped;
    int                         n_extracts;
    int                         n_empty;
    int                         n_replies;
    int                         peak_count;
    int                         rx_idle_rate;
    int                         rx_stall_left;

    binary_min_heap_priority_queue_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic bit key_precedes(input key_t a, input key_t b);
        if (order_signed)
            return $signed(a) < $signed(b);
        return a < b;
    endfunction

    task automatic predict_heap_op(input logic op, input key_t key, output heap_reply_t reply);
        int   pos;
        int   parent;
        int   best;
        int   child;
        key_t held;
        reply.min_key = '0;
        reply.status  = ST_OK;
        if (op == OP_INSERT)
        begin
            n_inserts++;
            if (model_count >= CAPACITY)
            begin
                reply.status = ST_FULL;
                n_dropped++;
            end
            else
            begin
                pos = model_count;
                model_keys[pos] = key;
                model_count++;
                while (pos > 0)
                begin
                    parent = (pos - 1) / 2;
                    if (!key_precedes(model_keys[pos], model_keys[parent]))
                        break;
                    held               = model_keys[pos];
                    model_keys[pos]    = model_keys[parent];
                    model_keys[parent] = held;
                    pos = parent;
                end
            end
        end
        else
        begin
            n_extracts++;
            if (model_count == 0)
            begin
                reply.status = ST_EMPTY;
                n_empty++;
            end
            else
            begin
                reply.min_key = model_keys[0];
                model_count--;
                model_keys[0] = model_keys[model_count];
                pos = 0;
                while (1)
                begin
                    best = pos;
                    for (child = 2 * pos + 1; child <= 2 * pos + 2; child++)
                        if (child < model_count && key_precedes(model_keys[child], model_keys[best]))
                            best = child;
                    if (best == pos)
                        break;
                    held             = model_keys[pos];
                    model_keys[pos]  = model_keys[best];
                    model_keys[best] = held;
                    pos = best;
                end
            end
        end
        reply.occupancy = CNT_W'(model_count);
        if (model_count > peak_count)
            peak_count = model_count;
    endtask

    task automatic send_beat(input logic op, input key_t key, input bit typed,
                             input heap_reply_t typed_reply);
        heap_reply_t predicted;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= key;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_heap_op(op, key, predicted);
        awaited_replies.push_back(typed ? typed_reply : predicted);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (awaited_replies.size() != 0)
            @(posedge clk);
    endtask

    // The ordering register is only touched once the queue has gone quiet.
    task automatic set_order(input bit sgn);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_COMPARE_SIGNED, 2'b00};
        pwdata  <= {{(CFG_DATA_W-1){1'b0}}, sgn};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== {{(CFG_DATA_W-1){1'b0}}, sgn})
        begin
            $error("compare_signed: expected %0h, got %0h", sgn, prdata);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        order_signed = sgn;
    endtask

    always @(posedge clk)
    begin
        heap_reply_t exp_reply;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                n_replies++;
                if (awaited_replies.size() == 0)
                begin
                    $error("unexpected beat: min_key %h status %0d occupancy %0d",
                           m_tdata[KEY_WIDTH-1:0], m_tuser, m_tdata[KEY_WIDTH +: CNT_W]);
                    error_count++;
                end
                else
                begin
                    exp_reply = awaited_replies.pop_front();
                    if (m_tdata[KEY_WIDTH-1:0] !== exp_reply.min_key)
                    begin
                        $error("min_key: expected %h, got %h",
                               exp_reply.min_key, m_tdata[KEY_WIDTH-1:0]);
                        error_count++;
                    end
                    if (m_tuser !== exp_reply.status)
                    begin
                        $error("status: expected %0d, got %0d", exp_reply.status, m_tuser);
                        error_count++;
                    end
                    if (m_tdata[KEY_WIDTH +: CNT_W] !== exp_reply.occupancy)
                    begin
                        $error("occupancy: expected %0d, got %0d",
                               exp_reply.occupancy, m_tdata[KEY_WIDTH +: CNT_W]);
                        error_count++;
                    end
                end
            end
            if (rx_stall_left > 0)
            begin
                rx_stall_left--;
                m_tready <= 1'b0;
            end
            else if (rx_idle_rate != 0 && $urandom_range(0, 15) < rx_idle_rate)
            begin
                rx_stall_left = $urandom_range(0, 17);
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("binary_min_heap_priority_queue_unit regression: fail");
        $finish;
    end

    initial
    begin
        logic op;
        key_t key;
        int   insert_pct;
        int   tx_idle_rate;
        rst_n    <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_INSERT;
        s_tvalid <= 1'b0;
        m_tready <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        model_count   = 0;
        order_signed  = 1'b0;
        error_count   = 0;
        n_inserts     = 0;
        n_dropped     = 0;
        n_extracts    = 0;
        n_empty       = 0;
        n_replies     = 0;
        peak_count    = 0;
        rx_idle_rate  = 0;
        rx_stall_left = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            if (DIRECTED_STEPS[r].sgn != order_signed)
                set_order(DIRECTED_STEPS[r].sgn);
            send_beat(DIRECTED_STEPS[r].op, DIRECTED_STEPS[r].key,
                      DIRECTED_STEPS[r].typed, DIRECTED_STEPS[r].reply);
        end

        // Phases alternate the ordering and lean toward filling, draining or churning the heap.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            set_order(phase % 2);
            case (phase % 4)
                0:       insert_pct = 90;
                1:       insert_pct = 20;
                2:       insert_pct = 55;
                default: insert_pct = 45;
            endcase
            if (phase == PHASES - 1)
            begin
                tx_idle_rate = 0;
                rx_idle_rate = 0;
            end
            else
            begin
                tx_idle_rate = $urandom_range(0, 4);
                rx_idle_rate = $urandom_range(0, 4);
            end
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (tx_idle_rate != 0 && $urandom_range(0, 15) < tx_idle_rate)
                begin
                    s_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 18)) @(posedge clk);
                end
                op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_EXTRACT;
                case ($urandom_range(0, 9))
                    0:       key = '0;
                    1:       key = '1;
                    2:       key = 32'h8000_0000;
                    3:       key = 32'h7FFF_FFFF;
                    4:       key = $urandom_range(0, 7);
                    5:       key = 32'h8000_0000 + $urandom_range(0, 7) - 4;
                    6:       key = 32'hFFFF_FFF8 + $urandom_range(0, 7);
                    default: key = $urandom();
                endcase
                send_beat(op, key, 1'b0, '0);
                if (phase == 2 && i == PHASE_ITEMS / 2)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Checked %0d result beats: %0d inserts (%0d dropped as full), %0d extracts",
                 n_replies, n_inserts, n_dropped, n_extracts);
        $display("(%0d on an empty heap), both key orderings, peak occupancy %0d of %0d.",
                 n_empty, peak_count, CAPACITY);
        if (error_count == 0)
            $display("binary_min_heap_priority_queue_unit regression: pass");
        else
            $display("binary_min_heap_priority_queue_unit regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
